### hw/rtl/ms_timer_callback_table_unit_defines.svh
// Assertion macros shared by the timer table RTL.
`ifndef MS_TIMER_CALLBACK_TABLE_UNIT_DEFINES_SVH
`define MS_TIMER_CALLBACK_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define MS_TMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define MS_TMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ms_tmr_pkg.sv
// Types and constants for the millisecond timer callback table.
package ms_tmr_pkg;

    localparam int ID_W      = 8;
    localparam int PER_W     = 16;
    localparam int TIME_W    = 32;
    localparam int SLOT_W    = 3;
    localparam int MAX_FIRES = 8;
    localparam int FCNT_W    = 4;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_START_CONT = 2'd1,
        OP_START_ONE  = 2'd2,
        OP_HALT       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_START_ACK = 2'd0,
        KIND_HALT_ACK  = 2'd1,
        KIND_FIRED     = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    // One table entry as held in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] due;
    } t_slot_word;

    localparam int WORD_W = $bits(t_slot_word);

    typedef struct packed {
        logic [TIME_W-1:0] add_a;
        logic [PER_W-1:0]  add_b;
        logic [TIME_W-1:0] cmp_a;
        logic [TIME_W-1:0] cmp_b;
    } t_alu_in;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              le;
    } t_alu_out;

endpackage

### hw/rtl/ms_timer_callback_table_unit.sv
// Top level of the millisecond timer callback table.
// Usage: one input channel (i_in_valid / o_in_stall) carries items with an op,
// a callback id and a period. One output channel (o_out_valid / i_out_stall)
// carries result items; o_last marks the final result of each input item.
// A start takes the lowest free slot and answers with one ack (status 1 when
// the table is full). A halt frees every slot with the given id and answers
// with one ack. A tick advances the millisecond time by one and then walks the
// table, giving one fired result per due slot (at most eight are reported) or
// a single "nothing fired" result.
// Timing: the block works on one item at a time and holds o_in_stall high
// from the cycle after acceptance until the item's final result is loaded
// into the output register, for longer when the output stalls; the next item
// can be taken in the cycle after that. The slot memory has a single read
// port and is walked one slot per cycle through the shared adder/comparator
// unless the walk pauses as below. The output register lets a new item be
// accepted while the last result of the previous item still waits. When the
// receiver stalls, the output register holds its result and the walk pauses
// at a reported fire while an earlier fire is still held. Reset (synchronous,
// active low) sets the time to zero, marks every slot free and empties the
// output register.
`include "ms_timer_callback_table_unit_defines.svh"

module ms_timer_callback_table_unit #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_callback_id,
    input  logic [15:0] i_period_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic        o_status,
    output logic [2:0]  o_slot,
    output logic [7:0]  o_fired_id,
    output logic [31:0] o_time_ms,
    output logic        o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ID_W  = ms_tmr_pkg::ID_W;
    localparam int PER_W = ms_tmr_pkg::PER_W;
    localparam int TM_W  = ms_tmr_pkg::TIME_W;
    localparam int SL_W  = ms_tmr_pkg::SLOT_W;
    localparam int FC_W  = ms_tmr_pkg::FCNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    // Control state.
    t_state            r_state,    n_state;
    logic [TM_W-1:0]   r_now,      n_now;
    logic [SLOTS-1:0]  r_valid,    n_valid;
    logic [CNT_W-1:0]  r_rd_idx,   n_rd_idx;
    logic              r_chk_vld,  n_chk_vld;
    logic [FC_W-1:0]   r_fcnt,     n_fcnt;
    logic              r_pend_vld, n_pend_vld;
    logic              r_out_vld,  n_out_vld;

    // Payload registers.
    ms_tmr_pkg::t_op   r_op,       n_op;
    logic [ID_W-1:0]   r_id,       n_id;
    logic [PER_W-1:0]  r_per,      n_per;
    logic [IDX_W-1:0]  r_chk_idx,  n_chk_idx;
    ms_tmr_pkg::t_kind r_pend_kind, n_pend_kind;
    logic              r_pend_status, n_pend_status;
    logic [SL_W-1:0]   r_pend_slot, n_pend_slot;
    logic [ID_W-1:0]   r_pend_id,  n_pend_id;
    ms_tmr_pkg::t_kind r_out_kind, n_out_kind;
    logic              r_out_status, n_out_status;
    logic [SL_W-1:0]   r_out_slot, n_out_slot;
    logic [ID_W-1:0]   r_out_id,   n_out_id;
    logic [TM_W-1:0]   r_out_time, n_out_time;
    logic              r_out_last, n_out_last;

    // Slot memory and shared arithmetic.
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    ms_tmr_pkg::t_slot_word w_wr_word;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;
    ms_tmr_pkg::t_slot_word w_rd_word;
    ms_tmr_pkg::t_alu_in    w_alu_in;
    ms_tmr_pkg::t_alu_out   w_alu_out;

    logic                   w_in_acc;
    logic                   w_out_busy;
    logic                   w_is_start;
    logic                   w_hit;
    logic                   w_report;
    logic                   w_adv;
    logic [IDX_W-1:0]       w_scan_idx;
    logic [IDX_W+SL_W-1:0]  w_scan_ext;
    logic [IDX_W+SL_W-1:0]  w_chk_ext;

    ms_tmr_ram #(
        .WIDTH (ms_tmr_pkg::WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_word)
    );

    ms_tmr_alu u_alu (
        .i_req (w_alu_in),
        .o_res (w_alu_out)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_busy = r_out_vld && i_out_stall;
    assign w_is_start = (r_op == ms_tmr_pkg::OP_START_CONT) ||
                        (r_op == ms_tmr_pkg::OP_START_ONE);

    assign w_scan_idx = r_rd_idx[IDX_W-1:0];
    assign w_scan_ext = {{SL_W{1'b0}}, w_scan_idx};
    assign w_chk_ext  = {{SL_W{1'b0}}, r_chk_idx};

    // A start adds the delay to the current time; a walk adds a slot's period
    // to its due time. The compare always checks the slot just read.
    always_comb begin
        w_alu_in.add_a = w_is_start ? r_now : w_rd_word.due;
        w_alu_in.add_b = w_is_start ? r_per : w_rd_word.period;
        w_alu_in.cmp_a = w_rd_word.due;
        w_alu_in.cmp_b = r_now;
    end

    assign w_hit    = r_chk_vld && r_valid[r_chk_idx] && w_alu_out.le;
    assign w_report = w_hit && (r_fcnt < FC_W'(ms_tmr_pkg::MAX_FIRES));
    // The walk pauses only when a second fire must push the held one out
    // while the output register is still occupied.
    assign w_adv    = !(w_report && r_pend_vld && w_out_busy);

    always_comb begin
        n_state       = r_state;
        n_now         = r_now;
        n_valid       = r_valid;
        n_rd_idx      = r_rd_idx;
        n_chk_vld     = r_chk_vld;
        n_chk_idx     = r_chk_idx;
        n_fcnt        = r_fcnt;
        n_pend_vld    = r_pend_vld;
        n_op          = r_op;
        n_id          = r_id;
        n_per         = r_per;
        n_pend_kind   = r_pend_kind;
        n_pend_status = r_pend_status;
        n_pend_slot   = r_pend_slot;
        n_pend_id     = r_pend_id;
        n_out_vld     = r_out_vld;
        n_out_kind    = r_out_kind;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_id      = r_out_id;
        n_out_time    = r_out_time;
        n_out_last    = r_out_last;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_chk_idx;
        w_wr_word     = w_rd_word;
        w_rd_en       = 1'b0;
        w_rd_addr     = w_scan_idx;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op       = ms_tmr_pkg::t_op'(i_op);
                    n_id       = i_callback_id;
                    n_per      = i_period_ms;
                    n_rd_idx   = '0;
                    n_chk_vld  = 1'b0;
                    n_fcnt     = '0;
                    n_pend_vld = 1'b0;
                    n_state    = S_SCAN;
                    if (ms_tmr_pkg::t_op'(i_op) == ms_tmr_pkg::OP_TICK) begin
                        n_now = r_now + TM_W'(1);
                    end
                end
            end

            S_SCAN: begin
                if (w_is_start) begin
                    // Look for the lowest free slot, one per cycle.
                    if (!r_valid[w_scan_idx]) begin
                        w_wr_en          = 1'b1;
                        w_wr_addr        = w_scan_idx;
                        w_wr_word.id     = r_id;
                        w_wr_word.period = (r_op == ms_tmr_pkg::OP_START_CONT) ?
                                           r_per : '0;
                        w_wr_word.due    = w_alu_out.sum;
                        n_valid[w_scan_idx] = 1'b1;
                        n_pend_kind   = ms_tmr_pkg::KIND_START_ACK;
                        n_pend_status = 1'b0;
                        n_pend_slot   = w_scan_ext[SL_W-1:0];
                        n_pend_id     = '0;
                        n_state       = S_FIN;
                    end else if (r_rd_idx == CNT_W'(SLOTS - 1)) begin
                        n_pend_kind   = ms_tmr_pkg::KIND_START_ACK;
                        n_pend_status = 1'b1;
                        n_pend_slot   = '0;
                        n_pend_id     = '0;
                        n_state       = S_FIN;
                    end else begin
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                    end
                end else if (w_adv) begin
                    // Read stage runs one slot ahead of the check stage.
                    w_rd_en   = (r_rd_idx < CNT_W'(SLOTS));
                    n_chk_vld = w_rd_en;
                    n_chk_idx = w_scan_idx;
                    if (w_rd_en) begin
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                    end

                    if (r_chk_vld) begin
                        if (r_op == ms_tmr_pkg::OP_HALT) begin
                            if (r_valid[r_chk_idx] && (w_rd_word.id == r_id)) begin
                                n_valid[r_chk_idx] = 1'b0;
                            end
                        end else if (w_hit) begin
                            if (w_rd_word.period == '0) begin
                                n_valid[r_chk_idx] = 1'b0;
                            end else begin
                                w_wr_en       = 1'b1;
                                w_wr_addr     = r_chk_idx;
                                w_wr_word.due = w_alu_out.sum;
                            end
                            if (w_report) begin
                                // The held fire is not the last one; send it on.
                                if (r_pend_vld) begin
                                    n_out_vld    = 1'b1;
                                    n_out_kind   = r_pend_kind;
                                    n_out_status = r_pend_status;
                                    n_out_slot   = r_pend_slot;
                                    n_out_id     = r_pend_id;
                                    n_out_time   = r_now;
                                    n_out_last   = 1'b0;
                                end
                                n_pend_vld    = 1'b1;
                                n_pend_kind   = ms_tmr_pkg::KIND_FIRED;
                                n_pend_status = 1'b0;
                                n_pend_slot   = w_chk_ext[SL_W-1:0];
                                n_pend_id     = w_rd_word.id;
                                n_fcnt        = r_fcnt + FC_W'(1);
                            end
                        end
                    end

                    if (!w_rd_en && !r_chk_vld) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (!w_out_busy) begin
                    n_out_vld  = 1'b1;
                    n_out_time = r_now;
                    n_out_last = 1'b1;
                    if (r_op == ms_tmr_pkg::OP_HALT) begin
                        n_out_kind   = ms_tmr_pkg::KIND_HALT_ACK;
                        n_out_status = 1'b0;
                        n_out_slot   = '0;
                        n_out_id     = '0;
                    end else if (w_is_start || r_pend_vld) begin
                        n_out_kind   = r_pend_kind;
                        n_out_status = r_pend_status;
                        n_out_slot   = r_pend_slot;
                        n_out_id     = r_pend_id;
                    end else begin
                        n_out_kind   = ms_tmr_pkg::KIND_NONE;
                        n_out_status = 1'b0;
                        n_out_slot   = '0;
                        n_out_id     = '0;
                    end
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_now      <= '0;
            r_valid    <= '0;
            r_rd_idx   <= '0;
            r_chk_vld  <= 1'b0;
            r_fcnt     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_valid    <= n_valid;
            r_rd_idx   <= n_rd_idx;
            r_chk_vld  <= n_chk_vld;
            r_fcnt     <= n_fcnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_op          <= n_op;
        r_id          <= n_id;
        r_per         <= n_per;
        r_chk_idx     <= n_chk_idx;
        r_pend_kind   <= n_pend_kind;
        r_pend_status <= n_pend_status;
        r_pend_slot   <= n_pend_slot;
        r_pend_id     <= n_pend_id;
        r_out_kind    <= n_out_kind;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_out_id      <= n_out_id;
        r_out_time    <= n_out_time;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;
    assign o_fired_id  = r_out_id;
    assign o_time_ms   = r_out_time;
    assign o_last      = r_out_last;

    `MS_TMR_ASSERT_NXT(a_tick_advances_time, w_in_acc && (i_op == ms_tmr_pkg::OP_TICK), r_now == $past(r_now) + 32'd1, "tick did not advance the time by one")
    `MS_TMR_ASSERT_IMP(a_fire_count_bound, 1'b1, r_fcnt <= FC_W'(ms_tmr_pkg::MAX_FIRES), "reported fire count exceeds its limit")
    `MS_TMR_ASSERT_IMP(a_idle_pipe_empty, r_state == S_IDLE, !r_chk_vld, "check stage busy while idle")
    `MS_TMR_ASSERT_IMP(a_status_start_only, o_out_valid && (o_kind != ms_tmr_pkg::KIND_START_ACK), !o_status, "full status on a result that is not a start ack")

endmodule

### hw/rtl/ms_tmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ms_tmr_ram #(
    parameter  int WIDTH  = 56,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ms_tmr_alu.sv
// Shared due-time adder and unsigned due-versus-now comparator.
module ms_tmr_alu (
    input  ms_tmr_pkg::t_alu_in  i_req,
    output ms_tmr_pkg::t_alu_out o_res
);

    // The period is zero-extended; the sum wraps modulo 2^32.
    assign o_res.sum = i_req.add_a
                     + {{(ms_tmr_pkg::TIME_W - ms_tmr_pkg::PER_W){1'b0}}, i_req.add_b};
    assign o_res.le  = (i_req.cmp_a <= i_req.cmp_b);

endmodule
